/* design/egp_pkg.sv */
// Shared types and constants for the Exp-Golomb encoder and byte packer.
`default_nettype none
package egp_pkg;

    localparam int WORD_W = 32;
    localparam int M_W    = 5;
    localparam int LEN_W  = 7;
    localparam int NB_W   = 4;
    localparam int ACC_W  = 72;
    localparam int BYTE_W = 8;

    localparam logic [WORD_W-1:0] UE_W_MAX = 32'hFFFF_FFFF;
    localparam logic [30:0]       SE_MAX   = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_UE    = 2'd0,
        FUNC_SE    = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic [ACC_W-1:0] w_sh;
        logic [NB_W-1:0]  nbytes;
    } t_entry;

endpackage
`default_nettype wire

/* design/egp_ifs.sv */
// Valid/ready channel interfaces for the input items and the output bytes.
`default_nettype none
interface egp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [32:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface egp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

/* design/egp_front.sv */
// Front end: maps values to code words, finds code length, aligns bits for the packer.
`default_nettype none
module egp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    egp_in_if.sink             i_in,
    output egp_pkg::t_entry    o_entry,
    output logic               o_push,
    input  wire logic          i_fifo_ready
);

    typedef enum logic [1:0] {
        CLS_CODE,
        CLS_FLUSH,
        CLS_DROP
    } t_cls;

    localparam int PAD_W = egp_pkg::ACC_W - egp_pkg::WORD_W;

    logic                          r_s1_valid;
    t_cls                          r_s1_cls;
    logic [egp_pkg::WORD_W-1:0]    r_s1_w;
    logic                          r_s2_valid;
    t_cls                          r_s2_cls;
    logic [egp_pkg::WORD_W-1:0]    r_s2_w;
    logic [egp_pkg::M_W-1:0]       r_s2_m;
    logic [2:0]                    r_pc;

    t_cls                          n_cls;
    logic [egp_pkg::WORD_W-1:0]    n_w;
    logic [egp_pkg::M_W-1:0]       n_m;
    logic [2:0]                    n_pc;
    logic [32:0]                   mag;
    logic [30:0]                   sat;
    logic [egp_pkg::LEN_W-1:0]     len;
    logic [egp_pkg::LEN_W-1:0]     shamt;
    logic                          need;
    logic                          en;

    // code word from the input value
    always_comb begin
        mag   = 33'(~i_in.value) + 33'd1;
        sat   = '0;
        n_w   = 32'd1;
        n_cls = CLS_DROP;
        case (i_in.func)
            egp_pkg::FUNC_UE: begin
                n_cls = CLS_CODE;
                if (i_in.value[32]) begin
                    n_w = 32'd1;
                end else if (i_in.value[31:0] == egp_pkg::UE_W_MAX) begin
                    n_w = egp_pkg::UE_W_MAX;
                end else begin
                    n_w = i_in.value[31:0] + 32'd1;
                end
            end
            egp_pkg::FUNC_SE: begin
                n_cls = CLS_CODE;
                if (i_in.value == '0) begin
                    n_w = 32'd1;
                end else if (!i_in.value[32]) begin
                    sat = i_in.value[31] ? egp_pkg::SE_MAX : i_in.value[30:0];
                    n_w = {sat, 1'b0};
                end else begin
                    sat = (mag[32] || mag[31]) ? egp_pkg::SE_MAX : mag[30:0];
                    n_w = {sat, 1'b1};
                end
            end
            egp_pkg::FUNC_FLUSH: n_cls = CLS_FLUSH;
            default:             n_cls = CLS_DROP;
        endcase
    end

    // index of the highest set bit
    always_comb begin
        n_m = '0;
        for (int i = 0; i < egp_pkg::WORD_W; i++) begin
            if (r_s1_w[i]) n_m = egp_pkg::M_W'(i);
        end
    end

    // place the code word right after the bits still waiting in the packer
    always_comb begin
        len            = egp_pkg::LEN_W'(r_pc) + egp_pkg::LEN_W'({r_s2_m, 1'b1});
        shamt          = egp_pkg::LEN_W'(egp_pkg::ACC_W) - len;
        o_entry.w_sh   = {{PAD_W{1'b0}}, r_s2_w} << shamt;
        o_entry.nbytes = egp_pkg::NB_W'(len[egp_pkg::LEN_W-1:3]);
        n_pc           = len[2:0];
        need           = 1'b0;
        case (r_s2_cls)
            CLS_CODE: need = 1'b1;
            CLS_FLUSH: begin
                need           = (r_pc != 3'd0);
                o_entry.w_sh   = '0;
                o_entry.nbytes = egp_pkg::NB_W'(1);
                n_pc           = 3'd0;
            end
            default: begin
                need = 1'b0;
                n_pc = r_pc;
            end
        endcase
    end

    assign en         = !r_s2_valid || !need || i_fifo_ready;
    assign o_push     = r_s2_valid && need && i_fifo_ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pc       <= 3'd0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cls <= n_cls;
            r_s1_w   <= n_w;
            r_s2_cls <= r_s1_cls;
            r_s2_w   <= r_s1_w;
            r_s2_m   <= n_m;
        end
    end

    a_nbytes_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_entry.nbytes <= egp_pkg::NB_W'(8)))
        else $error("entry carries more than eight bytes");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !en) |=> (r_s2_valid && $stable(r_s2_w) && $stable(r_pc)))
        else $error("stalled item lost in front end");

endmodule
`default_nettype wire

/* design/egp_fifo.sv */
// Small queue of aligned code entries between front end and packer.
`default_nettype none
module egp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire egp_pkg::t_entry  i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output egp_pkg::t_entry       o_data,
    output logic                  o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    egp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
            if (i_pop)  r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready) && !(i_pop && !o_valid))
        else $error("queue pushed when full or popped when empty");

endmodule
`default_nettype wire

/* design/egp_back.sv */
// Packer: merges waiting bits with each entry and sends out one byte per beat.
`default_nettype none
module egp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire egp_pkg::t_entry  i_entry,
    input  wire logic             i_valid,
    output logic                  o_pop,
    egp_out_if.source             o_out
);

    logic [egp_pkg::ACC_W-1:0]  r_acc;
    logic [egp_pkg::NB_W-1:0]   r_cnt;
    logic                       r_out_valid;
    logic [egp_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;

    logic                       load;
    logic [egp_pkg::ACC_W-1:0]  cur_acc;
    logic [egp_pkg::NB_W-1:0]   cur_cnt;
    logic                       out_free;
    logic                       emit;

    always_comb begin
        load     = (r_cnt == '0) && i_valid;
        cur_acc  = load ? (r_acc | i_entry.w_sh) : r_acc;
        cur_cnt  = load ? i_entry.nbytes : r_cnt;
        out_free = !r_out_valid || o_out.ready;
        emit     = (cur_cnt != '0) && out_free;
        o_pop    = load && ((i_entry.nbytes == '0) || out_free);
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_acc       <= cur_acc << egp_pkg::BYTE_W;
            r_cnt       <= cur_cnt - egp_pkg::NB_W'(1);
            r_out_valid <= 1'b1;
        end else begin
            if (o_pop) r_acc <= cur_acc;
            if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_acc[egp_pkg::ACC_W-1 -: egp_pkg::BYTE_W];
            r_out_last <= (cur_cnt == egp_pkg::NB_W'(1));
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= egp_pkg::NB_W'(8))
        else $error("byte count out of range");

    a_pending_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_acc[egp_pkg::ACC_W-8:0] == '0))
        else $error("stray bits below the waiting bits");

endmodule
`default_nettype wire

/* design/exp_golomb_encoder_packer.sv */
// Top level: order-0 Exp-Golomb encoder with big-endian byte packer.
// Throughput: one item per cycle while the queue has room; an item that completes
// n bytes holds the packer until all n are sent (one output byte per cycle while
// the sink is ready), the queue absorbing short bursts.
// Reset: synchronous active-low; clears pipeline, queue, waiting bits and count.
`default_nettype none
module exp_golomb_encoder_packer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    egp_in_if.sink     i_in,
    egp_out_if.source  o_out
);

    egp_pkg::t_entry push_entry;
    egp_pkg::t_entry pop_entry;
    logic            push;
    logic            fifo_ready;
    logic            fifo_valid;
    logic            pop;

    egp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_entry      (push_entry),
        .o_push       (push),
        .i_fifo_ready (fifo_ready)
    );

    egp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_ready (fifo_ready),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_valid (fifo_valid)
    );

    egp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (pop_entry),
        .i_valid (fifo_valid),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* test/exp_golomb_encoder_packer_tb.sv */
// Testbench: directed table and random items against an Exp-Golomb bitstream predictor.
`default_nettype none
module exp_golomb_encoder_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PHASE  = 60;
    localparam int N_DIRECTED   = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        egp_pkg::t_func func;
        logic [32:0]    value;
        logic           typed;
        logic [3:0]     n;
        logic [63:0]    bytes;
    } t_stim_row;

    // typed rows: n bytes, first byte in [63:56]
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{egp_pkg::FUNC_UE,    33'h0_0000_0000, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_FLUSH, 33'h0_0000_0000, 1'b1, 4'd1, 64'h8000_0000_0000_0000},
        '{egp_pkg::FUNC_FLUSH, 33'h0_0000_0000, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_NONE,  33'h1_2345_6789, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_UE,    33'h0_FFFF_FFFE, 1'b1, 4'd7, 64'h0000_0001_FFFF_FF00},
        '{egp_pkg::FUNC_FLUSH, 33'h0_0000_0000, 1'b1, 4'd1, 64'hFE00_0000_0000_0000},
        '{egp_pkg::FUNC_UE,    33'h1_FFFF_FFFF, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_UE,    33'h0_FFFF_FFFF, 1'b1, 4'd8, 64'h8000_0000_FFFF_FFFF},
        '{egp_pkg::FUNC_SE,    33'h0_0000_0000, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h0_0000_0001, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h1_FFFF_FFFF, 1'b1, 4'd0, 64'h0},
        '{egp_pkg::FUNC_FLUSH, 33'h0_0000_0000, 1'b1, 4'd1, 64'hA600_0000_0000_0000},
        '{egp_pkg::FUNC_SE,    33'h0_7FFF_FFFF, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h1_8000_0001, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h1_0000_0000, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h0_FFFF_FFFF, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h0_8000_0000, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h1_8000_0000, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_UE,    33'h1_0000_0000, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_UE,    33'h0_0000_0007, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_NONE,  33'h0_FFFF_FFFF, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_FLUSH, 33'h1_FFFF_FFFF, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_UE,    33'h0_5555_5555, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_SE,    33'h1_AAAA_AAAA, 1'b0, 4'd0, 64'h0},
        '{egp_pkg::FUNC_FLUSH, 33'h0_0000_0000, 1'b0, 4'd0, 64'h0}
    };

    localparam logic [32:0] EDGE_VALUES [10] = '{
        33'h0_0000_0000, 33'h1_FFFF_FFFF, 33'h0_FFFF_FFFE, 33'h0_FFFF_FFFF,
        33'h0_7FFF_FFFF, 33'h1_8000_0001, 33'h0_8000_0000, 33'h1_8000_0000,
        33'h1_0000_0000, 33'h0_0000_0001
    };

    logic i_clk;
    logic i_rst_n;

    egp_in_if  in_if ();
    egp_out_if out_if ();

    exp_golomb_encoder_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [6:0]  held_bits;
    int          held_count;
    logic [7:0]  coded_bytes [$];
    t_out_beat   due_bytes [$];
    t_out_beat   got_beat;
    t_out_beat   want_beat;
    int          mismatches;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Bitstream predictor: fills coded_bytes with the bytes one item completes.
    task automatic encode_item(input egp_pkg::t_func f, input logic [32:0] v);
        longint      sv;
        logic [31:0] w;
        logic [7:0]  acc;
        int          cnt;
        int          msb;
        int          i;
        logic        b;
        coded_bytes.delete();
        acc = {1'b0, held_bits};
        cnt = held_count;
        case (f)
            egp_pkg::FUNC_FLUSH: begin
                if (cnt != 0) begin
                    coded_bytes.push_back(acc << (8 - cnt));
                    acc = '0;
                    cnt = 0;
                end
            end
            egp_pkg::FUNC_UE, egp_pkg::FUNC_SE: begin
                sv = longint'($signed(v));
                if (f == egp_pkg::FUNC_UE) begin
                    if (sv < 0) sv = 0;
                    if (sv > 64'sd4294967294) sv = 64'sd4294967294;
                    w = 32'(sv + 1);
                end else begin
                    if (sv < -64'sd2147483647) sv = -64'sd2147483647;
                    if (sv > 64'sd2147483647) sv = 64'sd2147483647;
                    if (sv > 0) w = 32'(2 * sv);
                    else if (sv < 0) w = 32'(-2 * sv + 1);
                    else w = 32'd1;
                end
                msb = 0;
                for (i = 0; i < 32; i++) if (w[i]) msb = i;
                // msb leading zeros, then w from its top bit down
                for (i = 2 * msb; i >= 0; i--) begin
                    b = (i <= msb) ? w[i] : 1'b0;
                    acc = {acc[6:0], b};
                    cnt++;
                    if (cnt == 8) begin
                        coded_bytes.push_back(acc);
                        acc = '0;
                        cnt = 0;
                    end
                end
            end
            default: ;
        endcase
        held_bits  = acc[6:0];
        held_count = cnt;
    endtask

    task automatic push_item(input egp_pkg::t_func f, input logic [32:0] v,
                             input logic typed, input logic [3:0] n,
                             input logic [63:0] bytes);
        int k;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func  <= f;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        encode_item(f, v);
        if (typed) begin
            coded_bytes.delete();
            for (k = 0; k < n; k++) coded_bytes.push_back(bytes[63 - 8 * k -: 8]);
        end
        for (k = 0; k < coded_bytes.size(); k++)
            due_bytes.push_back('{coded_bytes[k], k == coded_bytes.size() - 1});
    endtask

    function automatic logic [32:0] pick_value(input egp_pkg::t_func f);
        int                 sel;
        int                 iv;
        logic [31:0]        mag;
        logic signed [32:0] sv;
        sel = $urandom_range(9);
        if (sel < 4) begin
            iv = int'($urandom_range(300));
            if (f == egp_pkg::FUNC_SE) iv = iv - 150;
            sv = 33'(iv);
            return sv;
        end else if (sel < 7) begin
            return 33'({$urandom, $urandom});
        end else if (sel < 9) begin
            mag = $urandom >> $urandom_range(31);
            sv = {1'b0, mag};
            if (f == egp_pkg::FUNC_SE && $urandom_range(1) == 1) sv = -sv;
            return sv;
        end
        return EDGE_VALUES[$urandom_range(9)];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_beat = '{out_if.out_byte, out_if.last};
            if (due_bytes.size() == 0) begin
                log_mismatch($sformatf("unexpected byte %02h last %0b",
                                       got_beat.data, got_beat.last));
            end else begin
                want_beat = due_bytes.pop_front();
                if (got_beat.data !== want_beat.data)
                    log_mismatch($sformatf("out_byte %02h, expected %02h",
                                           got_beat.data, want_beat.data));
                if (got_beat.last !== want_beat.last)
                    log_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                           got_beat.last, want_beat.last, want_beat.data));
            end
        end
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timed out with %0d bytes outstanding", due_bytes.size());
            $display("exp_golomb_encoder_packer regression: fail");
            $finish;
        end
    end

    initial begin
        int             i;
        int             phase;
        int             sent;
        int             r;
        egp_pkg::t_func f;
        t_stim_row      row;
        mismatches    = 0;
        cycle_count   = 0;
        held_bits     = '0;
        held_count    = 0;
        src_idle_pct  = 19;
        snk_stall_pct = 72;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.func    = egp_pkg::FUNC_NONE;
        in_if.value   = '0;
        out_if.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            push_item(row.func, row.value, row.typed, row.n, row.bytes);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 19; snk_stall_pct = 72; end
                1: begin src_idle_pct = 72; snk_stall_pct = 19; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            sent = 0;
            while (sent < ITEMS_PHASE) begin
                r = $urandom_range(99);
                if (r < 40) f = egp_pkg::FUNC_UE;
                else if (r < 80) f = egp_pkg::FUNC_SE;
                else if (r < 95) f = egp_pkg::FUNC_FLUSH;
                else f = egp_pkg::FUNC_NONE;
                push_item(f, pick_value(f), 1'b0, 4'd0, 64'h0);
                if (f != egp_pkg::FUNC_NONE) sent++;
            end
        end
        in_if.valid <= 1'b0;

        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("exp_golomb_encoder_packer regression: pass");
        else
            $display("exp_golomb_encoder_packer regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
